FILE: design/nalc_pkg.sv
// Shared types, constants and fixed-point helpers of the notch and NLMS line canceller.
package nalc_pkg;

   // History and weight store geometry; the history depth must be a power of two.
   localparam int TAPS       = 64;
   localparam int TAP_AW     = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int HIST_DEPTH = 4096;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);

   // Field and datapath widths.
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 24;
   localparam int WEIGHT_W = 32;
   localparam int MUL_A_W  = 48;
   localparam int MUL_B_W  = 24;
   localparam int PROD_W   = 72;
   localparam int ACC_W    = 64;
   localparam int POW_W    = 37;
   localparam int DEN_W    = 37;
   localparam int QUO_W    = 48;
   localparam int KEPT_W   = 33;

   // Step size mu in Q.30 and the leak complement in Q.32.
   localparam int MU_Q30 = 107374;
   localparam int LEAK_C = 12885;

   // Rounding shifts of the fixed-point formats.
   localparam int NOTCH_FF_SHIFT = 7;
   localparam int NOTCH_SHIFT    = 22;
   localparam int PRED_SHIFT     = 30;
   localparam int NUM_SHIFT      = 15;
   localparam int LEAK_SHIFT     = 32;
   localparam int STEP_SHIFT     = 15;

   // Configuration register indexes.
   localparam logic [2:0] CSR_STAGE_ENABLES = 3'd0;
   localparam logic [2:0] CSR_NOTCH_B0      = 3'd1;
   localparam logic [2:0] CSR_NOTCH_B1      = 3'd2;
   localparam logic [2:0] CSR_NOTCH_B2      = 3'd3;
   localparam logic [2:0] CSR_NOTCH_A1      = 3'd4;
   localparam logic [2:0] CSR_NOTCH_A2      = 3'd5;
   localparam logic [2:0] CSR_PREDICT_DELAY = 3'd6;
   localparam logic [2:0] CSR_TAP_STRIDE    = 3'd7;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_NOTCH,
      ST_PASS1,
      ST_ERR,
      ST_DIV,
      ST_PASS2,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             start;
      logic [QUO_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_stat_type;

   // Round half toward plus infinity while shifting right by s.
   function automatic logic signed [PROD_W-1:0] rnd_shift(input logic signed [PROD_W-1:0] v,
                                                          input int unsigned s);
      logic signed [PROD_W-1:0] half;
      half = '0;
      half[s-1] = 1'b1;
      return (v + half) >>> s;
   endfunction

   // Clamp to the two's complement range of the given width.
   function automatic logic signed [PROD_W-1:0] sat_to(input logic signed [PROD_W-1:0] v,
                                                       input int unsigned bits);
      logic signed [PROD_W-1:0] top;
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      top = '0;
      top[bits-1] = 1'b1;
      hi = top - 1;
      lo = -top;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

endpackage

FILE: design/nalc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module nalc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/nalc_div.sv
// Restoring divider, one quotient bit per cycle.
module nalc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  nalc_pkg::div_req_type req,
   output nalc_pkg::div_stat_type stat
);

   localparam int CNT_W = $clog2(nalc_pkg::QUO_W);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [nalc_pkg::DEN_W-1:0]   rem_ff, rem_in;
   logic [nalc_pkg::QUO_W-1:0]   quo_ff, quo_in;
   logic [nalc_pkg::DEN_W-1:0]   divisor_ff, divisor_in;
   logic [nalc_pkg::DEN_W:0]     trial;
   logic                         fits;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, quo_ff[nalc_pkg::QUO_W-1]};
      fits       = (trial >= {1'b0, divisor_ff});
      if (req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? nalc_pkg::DEN_W'(trial - {1'b0, divisor_ff})
                         : nalc_pkg::DEN_W'(trial);
         quo_in   = {quo_ff[nalc_pkg::QUO_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(nalc_pkg::QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

FILE: design/notch_and_nlms_line_canceller.sv
// Top level of the notch and NLMS line canceller: sequencer, shared multiplier, stores.
//
// One audio sample enters per transfer on the req_ channel and one processed sample leaves
// per transfer on the rsp_ channel, in order. Both are signed Q1.15 in tdata[15:0].
// The csr_ port writes one configuration register per cycle with csr_we high; it is to be
// written only while the block is idle, a rule on the user that the block does not enforce.
//
// Each sample is worked by a small sequencer around one 48x24 multiplier: the notch first,
// then the canceller, which makes two passes over the 64 taps, each tap by the steps read,
// multiply, multiply, accumulate or write back, and in between runs a 48-step restoring
// divider for the normalized step. Either stage may be switched off. The block takes one
// sample at a time: req_tready is high only while it waits for a new sample.
//
// After reset a clearing pass writes zero through the 4096-entry history and the weights;
// no sample is accepted meanwhile, but register writes are taken.
// The result sits in an output register, so a new sample is accepted while rsp_tvalid is
// held by a stalled receiver; the next result then waits until that transfer completes.
module notch_and_nlms_line_canceller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample_out
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int SW  = nalc_pkg::SAMPLE_W;
   localparam int CW  = nalc_pkg::COEF_W;
   localparam int WW  = nalc_pkg::WEIGHT_W;
   localparam int AW  = nalc_pkg::MUL_A_W;
   localparam int BW  = nalc_pkg::MUL_B_W;
   localparam int PW  = nalc_pkg::PROD_W;
   localparam int HAW = nalc_pkg::HIST_AW;
   localparam int TAW = nalc_pkg::TAP_AW;

   // Configuration registers.
   logic [1:0]           stage_enables_ff;
   logic signed [CW-1:0] notch_b0_ff, notch_b1_ff, notch_b2_ff, notch_a1_ff, notch_a2_ff;
   logic [10:0]          predict_delay_ff;
   logic [5:0]           tap_stride_ff;

   // Sequencer and datapath state.
   nalc_pkg::state_type  state_ff, state_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic [TAW-1:0]       tap_ff, tap_in;
   logic [HAW-1:0]       back_ff, back_in;
   logic [HAW-1:0]       wp_ff, wp_in;
   logic [HAW-1:0]       clr_ff, clr_in;
   logic signed [SW-1:0] x_ff, x_in;
   logic signed [SW-1:0] v_ff, v_in;
   logic signed [SW-1:0] e_ff, e_in;
   logic signed [SW-1:0] r_ff, r_in;
   logic signed [SW-1:0] ni1_ff, ni1_in, ni2_ff, ni2_in;
   logic signed [CW-1:0] no1_ff, no1_in, no2_ff, no2_in;
   logic signed [nalc_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [nalc_pkg::POW_W-1:0]         pow_ff, pow_in;
   logic signed [PW-1:0]               prod_ff, prod_in;
   logic signed [nalc_pkg::KEPT_W-1:0] kept_ff, kept_in;
   logic signed [nalc_pkg::QUO_W-1:0]  ge_ff, ge_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]        rsp_data_ff, rsp_data_in;

   // Shared multiplier operands.
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;

   // Store ports.
   logic                 hist_we;
   logic [HAW-1:0]       hist_waddr, hist_raddr;
   logic [SW-1:0]        hist_wdata, hist_rdata;
   logic                 w_we;
   logic [TAW-1:0]       w_waddr, w_raddr;
   logic [WW-1:0]        w_wdata, w_rdata;

   nalc_pkg::div_req_type  div_req;
   nalc_pkg::div_stat_type div_stat;

   // Combinational helpers.
   logic signed [PW-1:0]    notch_y, notch_v, upd_sum;
   logic signed [BW-1:0]    e_mag;
   logic [nalc_pkg::DEN_W-1:0] den;
   logic [nalc_pkg::QUO_W-1:0] num;
   logic                    load;

   nalc_ram #(.WIDTH(SW), .DEPTH(nalc_pkg::HIST_DEPTH)) u_hist (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .raddr (hist_raddr),
      .rdata (hist_rdata)
   );

   nalc_ram #(.WIDTH(WW), .DEPTH(nalc_pkg::TAPS)) u_weights (
      .clock (clock),
      .we    (w_we),
      .waddr (w_waddr),
      .wdata (w_wdata),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   nalc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .stat  (div_stat)
   );

   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      tap_in     = tap_ff;
      back_in    = back_ff;
      wp_in      = wp_ff;
      clr_in     = clr_ff;
      x_in       = x_ff;
      v_in       = v_ff;
      e_in       = e_ff;
      r_in       = r_ff;
      ni1_in     = ni1_ff;
      ni2_in     = ni2_ff;
      no1_in     = no1_ff;
      no2_in     = no2_ff;
      acc_in     = acc_ff;
      pow_in     = pow_ff;
      kept_in    = kept_ff;
      ge_in      = ge_ff;
      rsp_data_in = rsp_data_ff;
      mul_a      = '0;
      mul_b      = '0;
      hist_we    = 1'b0;
      hist_waddr = wp_ff;
      hist_wdata = v_ff;
      hist_raddr = wp_ff - back_ff;
      w_we       = 1'b0;
      w_waddr    = tap_ff;
      w_wdata    = '0;
      w_raddr    = tap_ff;
      req_tready = 1'b0;
      load       = 1'b0;
      div_req    = '0;
      notch_y    = nalc_pkg::sat_to(nalc_pkg::rnd_shift(PW'(acc_ff), nalc_pkg::NOTCH_SHIFT), CW);
      notch_v    = nalc_pkg::sat_to(nalc_pkg::rnd_shift(notch_y, nalc_pkg::NOTCH_FF_SHIFT), SW);
      upd_sum    = PW'(kept_ff) + nalc_pkg::rnd_shift(prod_ff, nalc_pkg::STEP_SHIFT);
      e_mag      = e_ff[SW-1] ? -BW'(e_ff) : BW'(e_ff);
      den        = pow_ff + 1'b1;
      num        = {prod_ff[nalc_pkg::QUO_W-nalc_pkg::NUM_SHIFT-1:0],
                    {nalc_pkg::NUM_SHIFT{1'b0}}};

      case (state_ff)
         nalc_pkg::ST_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_ff;
            hist_wdata = '0;
            if ({1'b0, clr_ff} < (HAW+1)'(nalc_pkg::TAPS)) begin
               w_we    = 1'b1;
               w_waddr = clr_ff[TAW-1:0];
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == HAW'(nalc_pkg::HIST_DEPTH - 1)) begin
               state_in = nalc_pkg::ST_IDLE;
            end
         end
         nalc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               x_in    = req_tdata;
               v_in    = req_tdata;
               cnt_in  = '0;
               tap_in  = '0;
               acc_in  = '0;
               pow_in  = '0;
               back_in = HAW'(predict_delay_ff);
               if (stage_enables_ff[0]) begin
                  state_in = nalc_pkg::ST_NOTCH;
               end else if (stage_enables_ff[1]) begin
                  state_in = nalc_pkg::ST_PASS1;
               end else begin
                  state_in = nalc_pkg::ST_FINISH;
               end
            end
         end
         nalc_pkg::ST_NOTCH: begin
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               3'd0: begin
                  mul_a = AW'(notch_b0_ff);
                  mul_b = BW'(x_ff);
               end
               3'd1: begin
                  mul_a  = AW'(notch_b1_ff);
                  mul_b  = BW'(ni1_ff);
                  acc_in = acc_ff + nalc_pkg::ACC_W'(prod_ff <<< nalc_pkg::NOTCH_FF_SHIFT);
               end
               3'd2: begin
                  mul_a  = AW'(notch_b2_ff);
                  mul_b  = BW'(ni2_ff);
                  acc_in = acc_ff + nalc_pkg::ACC_W'(prod_ff <<< nalc_pkg::NOTCH_FF_SHIFT);
               end
               3'd3: begin
                  mul_a  = AW'(notch_a1_ff);
                  mul_b  = BW'(no1_ff);
                  acc_in = acc_ff + nalc_pkg::ACC_W'(prod_ff <<< nalc_pkg::NOTCH_FF_SHIFT);
               end
               3'd4: begin
                  mul_a  = AW'(notch_a2_ff);
                  mul_b  = BW'(no2_ff);
                  acc_in = acc_ff - nalc_pkg::ACC_W'(prod_ff);
               end
               3'd5: begin
                  acc_in = acc_ff - nalc_pkg::ACC_W'(prod_ff);
               end
               default: begin
                  // The sum is complete: round, saturate and shift the delay lines.
                  no2_in  = no1_ff;
                  no1_in  = notch_y[CW-1:0];
                  ni2_in  = ni1_ff;
                  ni1_in  = x_ff;
                  v_in    = notch_v[SW-1:0];
                  cnt_in  = '0;
                  acc_in  = '0;
                  pow_in  = '0;
                  tap_in  = '0;
                  back_in = HAW'(predict_delay_ff);
                  state_in = stage_enables_ff[1] ? nalc_pkg::ST_PASS1 : nalc_pkg::ST_FINISH;
               end
            endcase
         end
         nalc_pkg::ST_PASS1: begin
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               3'd0: begin
                  // Addresses of this tap are on the store read ports.
               end
               3'd1: begin
                  mul_a = AW'($signed(w_rdata));
                  mul_b = BW'($signed(hist_rdata));
                  r_in  = $signed(hist_rdata);
               end
               3'd2: begin
                  acc_in = acc_ff + nalc_pkg::ACC_W'(prod_ff);
                  mul_a  = AW'(r_ff);
                  mul_b  = BW'(r_ff);
               end
               default: begin
                  pow_in  = pow_ff + nalc_pkg::POW_W'(prod_ff);
                  back_in = back_ff + HAW'(tap_stride_ff);
                  cnt_in  = '0;
                  if (tap_ff == TAW'(nalc_pkg::TAPS - 1)) begin
                     state_in = nalc_pkg::ST_ERR;
                  end else begin
                     tap_in = tap_ff + 1'b1;
                  end
               end
            endcase
         end
         nalc_pkg::ST_ERR: begin
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               3'd0: begin
                  e_in = SW'(nalc_pkg::sat_to(PW'(v_ff) - nalc_pkg::rnd_shift(PW'(acc_ff),
                             nalc_pkg::PRED_SHIFT), SW));
               end
               3'd1: begin
                  mul_a = AW'(nalc_pkg::MU_Q30);
                  mul_b = e_mag;
               end
               default: begin
                  div_req.start    = 1'b1;
                  div_req.dividend = num + nalc_pkg::QUO_W'(den >> 1);
                  div_req.divisor  = den;
                  state_in         = nalc_pkg::ST_DIV;
               end
            endcase
         end
         nalc_pkg::ST_DIV: begin
            if (div_stat.done) begin
               ge_in    = e_ff[SW-1] ? -$signed(div_stat.quotient) : $signed(div_stat.quotient);
               cnt_in   = '0;
               tap_in   = '0;
               back_in  = HAW'(predict_delay_ff);
               state_in = nalc_pkg::ST_PASS2;
            end
         end
         nalc_pkg::ST_PASS2: begin
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               3'd0: begin
                  // Addresses of this tap are on the store read ports.
               end
               3'd1: begin
                  mul_a = AW'($signed(w_rdata));
                  mul_b = BW'(nalc_pkg::LEAK_C);
                  r_in  = $signed(hist_rdata);
                  kept_in = nalc_pkg::KEPT_W'($signed(w_rdata));
               end
               3'd2: begin
                  kept_in = kept_ff - nalc_pkg::KEPT_W'(nalc_pkg::rnd_shift(prod_ff,
                                                         nalc_pkg::LEAK_SHIFT));
                  mul_a = AW'(ge_ff);
                  mul_b = BW'(r_ff);
               end
               default: begin
                  w_we    = 1'b1;
                  w_wdata = WW'(nalc_pkg::sat_to(upd_sum, WW));
                  back_in = back_ff + HAW'(tap_stride_ff);
                  cnt_in  = '0;
                  if (tap_ff == TAW'(nalc_pkg::TAPS - 1)) begin
                     state_in = nalc_pkg::ST_FINISH;
                  end else begin
                     tap_in = tap_ff + 1'b1;
                  end
               end
            endcase
         end
         nalc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load        = 1'b1;
               rsp_data_in = stage_enables_ff[1] ? e_ff : v_ff;
               hist_we     = stage_enables_ff[1];
               wp_in       = wp_ff + 1'b1;
               state_in    = nalc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nalc_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = load | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nalc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         ni1_ff       <= '0;
         ni2_ff       <= '0;
         no1_ff       <= '0;
         no2_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         ni1_ff       <= ni1_in;
         ni2_ff       <= ni2_in;
         no1_ff       <= no1_in;
         no2_ff       <= no2_in;
      end
      cnt_ff      <= cnt_in;
      tap_ff      <= tap_in;
      back_ff     <= back_in;
      x_ff        <= x_in;
      v_ff        <= v_in;
      e_ff        <= e_in;
      r_ff        <= r_in;
      acc_ff      <= acc_in;
      pow_ff      <= pow_in;
      prod_ff     <= prod_in;
      kept_ff     <= kept_in;
      ge_ff       <= ge_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers take a write whenever the enable is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_enables_ff <= '0;
         notch_b0_ff      <= CW'(4194304);
         notch_b1_ff      <= '0;
         notch_b2_ff      <= '0;
         notch_a1_ff      <= '0;
         notch_a2_ff      <= '0;
         predict_delay_ff <= 11'd240;
         tap_stride_ff    <= 6'd1;
      end else if (csr_we) begin
         case (csr_index)
            nalc_pkg::CSR_STAGE_ENABLES: stage_enables_ff <= csr_wdata[1:0];
            nalc_pkg::CSR_NOTCH_B0:      notch_b0_ff      <= csr_wdata;
            nalc_pkg::CSR_NOTCH_B1:      notch_b1_ff      <= csr_wdata;
            nalc_pkg::CSR_NOTCH_B2:      notch_b2_ff      <= csr_wdata;
            nalc_pkg::CSR_NOTCH_A1:      notch_a1_ff      <= csr_wdata;
            nalc_pkg::CSR_NOTCH_A2:      notch_a2_ff      <= csr_wdata;
            nalc_pkg::CSR_PREDICT_DELAY: predict_delay_ff <= csr_wdata[10:0];
            nalc_pkg::CSR_TAP_STRIDE:    tap_stride_ff    <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
